[hdl/c8ex_pkg.sv]
package c8ex_pkg;

    localparam int          REG_COUNT  = 16;
    localparam logic [3:0]  FLAG_REG   = 4'hF;
    localparam logic [11:0] PC_RESET   = 12'h200;
    localparam logic [11:0] FONT_RESET = 12'd80;
    localparam int          ROW_W      = 64;

    typedef enum logic [5:0] {
        OP_CLS     = 6'd0,  OP_RET     = 6'd1,  OP_JP      = 6'd2,  OP_CALL    = 6'd3,
        OP_SE_KK   = 6'd4,  OP_SNE_KK  = 6'd5,  OP_SE_XY   = 6'd6,  OP_LD_KK   = 6'd7,
        OP_ADD_KK  = 6'd8,  OP_LD_XY   = 6'd9,  OP_OR      = 6'd10, OP_AND     = 6'd11,
        OP_XOR     = 6'd12, OP_ADD_XY  = 6'd13, OP_SUB     = 6'd14, OP_SHR     = 6'd15,
        OP_SUBN    = 6'd16, OP_SHL     = 6'd17, OP_SNE_XY  = 6'd18, OP_LD_I    = 6'd19,
        OP_JP_V0   = 6'd20, OP_RND     = 6'd21, OP_DRW     = 6'd22, OP_SKP     = 6'd23,
        OP_SKNP    = 6'd24, OP_LD_VDT  = 6'd25, OP_LD_KEY  = 6'd26, OP_LD_DT   = 6'd27,
        OP_LD_ST   = 6'd28, OP_ADD_I   = 6'd29, OP_LD_F    = 6'd30, OP_BCD     = 6'd31,
        OP_STORE   = 6'd32, OP_LOAD    = 6'd33, OP_HOST_WR = 6'd34, OP_ROW_RD  = 6'd35
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_ADDR  = 2'd1,
        ERR_KEY   = 2'd2,
        ERR_STACK = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_FLAG, ST_MOD, ST_BCD, ST_STR, ST_STW,
        ST_LDR, ST_LDW, ST_DRR, ST_DRW, ST_DRF, ST_FIN
    } state_t;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [3:0]  reg_x;
        logic [3:0]  reg_y;
        logic [11:0] immediate;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
        logic [7:0]  host_data;
    } in_item_t;

    typedef struct packed {
        logic [11:0]      pc_value;
        logic             jumped;
        logic             waiting;
        logic [1:0]       error_code;
        logic [ROW_W-1:0] screen_row;
    } out_item_t;

endpackage

[hdl/chip8_instruction_execute_unit.sv]
// CHIP-8 instruction execute unit.
// Input channel s_valid/s_ready/s_item carries one decoded instruction per item;
// result channel m_valid/m_ready/m_item returns one item per instruction with the
// new PC, jump/wait flags, error code and, for a row read, the screen row.
// cfg_wr_en/cfg_wr_data set the font base; write only while the unit is idle.
// Most operations go from ST_EXEC straight to ST_FIN, where the result is loaded;
// ALU operations that also write VF pass through ST_FLAG first. BCD, block store/load
// and sprite draw first reduce I (and the draw origin) modulo the memory and screen
// sizes by repeated subtraction, then walk RAM: BCD writes three digits, store/load
// moves each register with a read then a write, draw reads then writes each sprite
// row and finishes by writing VF. One item is in flight at a time; the next is
// accepted on the cycle after its result is loaded into the output register, so a
// stalled receiver holds one finished item while the next instruction executes,
// and only a second finished result waits. The RAM, call stack, registers and
// screen sit in synchronous memories with registered reads. Reset (aresetn low,
// synchronous) clears registers, screen, index, stack pointer and timers, sets PC
// to 0x200 and font base to 80; RAM and call stack contents are undefined until written.
module chip8_instruction_execute_unit #(
    parameter int MEM_BYTES   = 4096,
    parameter int SCR_WIDTH   = 64,
    parameter int SCR_HEIGHT  = 32,
    parameter int STACK_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  c8ex_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output c8ex_pkg::out_item_t  m_item,
    input  logic                 cfg_wr_en,
    input  logic [11:0]          cfg_wr_data
);

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int HW  = $clog2(SCR_HEIGHT);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [12:0]    MEM_LIM  = 13'(MEM_BYTES);
    localparam logic [7:0]     SW_LIM   = 8'(SCR_WIDTH);
    localparam logic [7:0]     SH_LIM   = 8'(SCR_HEIGHT);
    localparam logic [SPW-1:0] SP_FULL  = SPW'(STACK_DEPTH);
    localparam logic [AW-1:0]  PTR_LAST = AW'(MEM_BYTES - 1);
    localparam logic [c8ex_pkg::ROW_W-1:0] CLIP_MASK =
        ~({c8ex_pkg::ROW_W{1'b1}} >> SCR_WIDTH);

    logic [7:0]                    gp_mem  [c8ex_pkg::REG_COUNT];
    logic [7:0]                    ram_mem [MEM_BYTES];
    logic [11:0]                   stk_mem [STACK_DEPTH];
    logic [c8ex_pkg::ROW_W-1:0]    scr_mem [SCR_HEIGHT];

    c8ex_pkg::state_t    state_reg, state_next;
    c8ex_pkg::in_item_t  item_reg, item_next;
    c8ex_pkg::out_item_t res_reg, res_next, m_item_reg, m_item_next;
    logic                m_valid_reg, m_valid_next;
    logic [11:0]         pc_reg, pc_next, i_reg, i_next, font_reg, font_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [7:0]          delay_reg, delay_next, sound_reg, sound_next;
    logic [15:0]         gp_vld_reg, gp_vld_next;
    logic [SCR_HEIGHT-1:0] scr_vld_reg, scr_vld_next;
    logic [7:0]          vx_reg, vx_next;
    logic                flag_reg, flag_next, hit_reg, hit_next;
    logic [11:0]         addr_reg, addr_next;
    logic [7:0]          x0_reg, x0_next, yw_reg, yw_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [3:0]          cnt_reg, cnt_next;

    logic [7:0]                 gp_rda_reg, gp_rdb_reg, ram_rd_reg;
    logic                       gp_rda_v_reg, gp_rdb_v_reg, scr_rd_v_reg;
    logic [11:0]                stk_rd_reg;
    logic [c8ex_pkg::ROW_W-1:0] scr_rd_reg;

    logic                       gp_we, ram_we, stk_we, scr_we;
    logic [3:0]                 gp_wa, gp_ra, gp_rb;
    logic [7:0]                 gp_wd, ram_wd;
    logic [AW-1:0]              ram_wa;
    logic [SIW-1:0]             stk_wa, stk_ra;
    logic [11:0]                stk_wd;
    logic [HW-1:0]              scr_wa, scr_ra;
    logic [c8ex_pkg::ROW_W-1:0] scr_wd;

    logic [7:0]  va, vb, kk, sub_xy, sub_yx;
    logic [8:0]  sum9;
    logic [12:0] sum_i, sum_v0;
    logic [11:0] nxt_pc, new_pc;
    logic        skip, jmp, wt;
    c8ex_pkg::err_t err;
    logic [c8ex_pkg::ROW_W-1:0] row_out, cur_row, spr_mask;
    logic [3:0]  key_lo;
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_r, bcd_o;
    logic [14:0] bcd_mul;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_dig;
    logic [AW-1:0] ptr_inc;
    c8ex_pkg::state_t exec_to;

    assign s_ready = (state_reg == c8ex_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign va      = gp_rda_v_reg ? gp_rda_reg : 8'd0;
    assign vb      = gp_rdb_v_reg ? gp_rdb_reg : 8'd0;
    assign kk      = item_reg.immediate[7:0];
    assign nxt_pc  = pc_reg + 12'd2;
    assign sum9    = {1'b0, va} + {1'b0, vb};
    assign sub_xy  = va - vb;
    assign sub_yx  = vb - va;
    assign sum_i   = {1'b0, i_reg} + 13'(va);
    assign sum_v0  = 13'(vb) + {1'b0, item_reg.immediate};
    assign ptr_inc = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + AW'(1);
    assign cur_row = scr_rd_v_reg ? scr_rd_reg : '0;
    assign spr_mask = ({ram_rd_reg, {(c8ex_pkg::ROW_W - 8){1'b0}}} >> x0_reg[5:0])
                      & CLIP_MASK;

    assign bcd_h   = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign bcd_r   = vx_reg - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
    assign bcd_mul = 15'(bcd_r[6:0]) * 15'd205;
    assign bcd_t   = bcd_mul[14:11];
    assign bcd_o   = bcd_r - {1'b0, bcd_t, 3'b000} - {3'b000, bcd_t, 1'b0};
    assign bcd_dig = (cnt_reg == 4'd0) ? {6'd0, bcd_h} :
                     ((cnt_reg == 4'd1) ? {4'd0, bcd_t} : {4'd0, bcd_o[3:0]});

    always_comb begin
        key_lo = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (item_reg.key_mask[k]) begin
                key_lo = 4'(k);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pc_next      = pc_reg;
        i_next       = i_reg;
        font_next    = cfg_wr_en ? cfg_wr_data : font_reg;
        sp_next      = sp_reg;
        delay_next   = delay_reg;
        sound_next   = sound_reg;
        gp_vld_next  = gp_vld_reg;
        scr_vld_next = scr_vld_reg;
        vx_next      = vx_reg;
        flag_next    = flag_reg;
        hit_next     = hit_reg;
        addr_next    = addr_reg;
        x0_next      = x0_reg;
        yw_next      = yw_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        gp_we  = 1'b0; gp_wa = item_reg.reg_x; gp_wd = 8'd0;
        ram_we = 1'b0; ram_wa = ptr_reg;      ram_wd = 8'd0;
        stk_we = 1'b0; stk_wa = sp_reg[SIW-1:0]; stk_wd = nxt_pc;
        scr_we = 1'b0; scr_wa = yw_reg[HW-1:0]; scr_wd = '0;
        gp_ra  = item_reg.reg_x;
        gp_rb  = item_reg.reg_y;
        scr_ra = yw_reg[HW-1:0];
        stk_ra = (sp_reg == '0) ? '0 : SIW'(sp_reg - SPW'(1));
        skip = 1'b0; jmp = 1'b0; wt = 1'b0; err = c8ex_pkg::ERR_OK;
        new_pc = nxt_pc; row_out = '0; exec_to = c8ex_pkg::ST_FIN;

        unique case (state_reg)
            c8ex_pkg::ST_IDLE: begin
                gp_ra = s_item.reg_x;
                gp_rb = (c8ex_pkg::op_t'(s_item.opcode) == c8ex_pkg::OP_JP_V0)
                        ? 4'd0 : s_item.reg_y;
                scr_ra = (s_item.immediate < 12'(SCR_HEIGHT))
                         ? s_item.immediate[HW-1:0] : '0;
                if (s_valid) begin
                    item_next  = s_item;
                    state_next = c8ex_pkg::ST_EXEC;
                end
            end
            c8ex_pkg::ST_EXEC: begin
                vx_next   = va;
                x0_next   = va;
                yw_next   = vb;
                addr_next = i_reg;
                cnt_next  = 4'd0;
                hit_next  = 1'b0;
                unique case (c8ex_pkg::op_t'(item_reg.opcode))
                    c8ex_pkg::OP_CLS: scr_vld_next = '0;
                    c8ex_pkg::OP_RET: begin
                        if (sp_reg == '0) begin
                            err = c8ex_pkg::ERR_STACK;
                        end else begin
                            sp_next = sp_reg - SPW'(1);
                            new_pc  = stk_rd_reg;
                            jmp     = 1'b1;
                        end
                    end
                    c8ex_pkg::OP_JP: begin
                        if ({1'b0, item_reg.immediate} >= MEM_LIM) begin
                            err = c8ex_pkg::ERR_ADDR;
                        end else begin
                            new_pc = item_reg.immediate;
                            jmp    = 1'b1;
                        end
                    end
                    c8ex_pkg::OP_CALL: begin
                        if ({1'b0, item_reg.immediate} >= MEM_LIM) begin
                            err = c8ex_pkg::ERR_ADDR;
                        end else if (sp_reg >= SP_FULL) begin
                            err = c8ex_pkg::ERR_STACK;
                        end else begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + SPW'(1);
                            new_pc  = item_reg.immediate;
                            jmp     = 1'b1;
                        end
                    end
                    c8ex_pkg::OP_SE_KK:  skip = (va == kk);
                    c8ex_pkg::OP_SNE_KK: skip = (va != kk);
                    c8ex_pkg::OP_SE_XY:  skip = (va == vb);
                    c8ex_pkg::OP_SNE_XY: skip = (va != vb);
                    c8ex_pkg::OP_LD_KK:  begin gp_we = 1'b1; gp_wd = kk; end
                    c8ex_pkg::OP_ADD_KK: begin gp_we = 1'b1; gp_wd = va + kk; end
                    c8ex_pkg::OP_LD_XY:  begin gp_we = 1'b1; gp_wd = vb; end
                    c8ex_pkg::OP_OR:     begin gp_we = 1'b1; gp_wd = va | vb; end
                    c8ex_pkg::OP_AND:    begin gp_we = 1'b1; gp_wd = va & vb; end
                    c8ex_pkg::OP_XOR:    begin gp_we = 1'b1; gp_wd = va ^ vb; end
                    c8ex_pkg::OP_ADD_XY: begin
                        gp_we = 1'b1; gp_wd = sum9[7:0]; flag_next = sum9[8];
                        exec_to = c8ex_pkg::ST_FLAG;
                    end
                    c8ex_pkg::OP_SUB: begin
                        gp_we = 1'b1; gp_wd = sub_xy; flag_next = (va >= vb);
                        exec_to = c8ex_pkg::ST_FLAG;
                    end
                    c8ex_pkg::OP_SHR: begin
                        gp_we = 1'b1; gp_wd = {1'b0, va[7:1]}; flag_next = va[0];
                        exec_to = c8ex_pkg::ST_FLAG;
                    end
                    c8ex_pkg::OP_SUBN: begin
                        gp_we = 1'b1; gp_wd = sub_yx; flag_next = (vb >= va);
                        exec_to = c8ex_pkg::ST_FLAG;
                    end
                    c8ex_pkg::OP_SHL: begin
                        gp_we = 1'b1; gp_wd = {va[6:0], 1'b0}; flag_next = va[7];
                        exec_to = c8ex_pkg::ST_FLAG;
                    end
                    c8ex_pkg::OP_LD_I: begin
                        if ({1'b0, item_reg.immediate} >= MEM_LIM) begin
                            err = c8ex_pkg::ERR_ADDR;
                        end else begin
                            i_next = item_reg.immediate;
                        end
                    end
                    c8ex_pkg::OP_JP_V0: begin
                        if (sum_v0 >= MEM_LIM) begin
                            err = c8ex_pkg::ERR_ADDR;
                        end else begin
                            new_pc = sum_v0[11:0];
                            jmp    = 1'b1;
                        end
                    end
                    c8ex_pkg::OP_RND: begin
                        gp_we = 1'b1; gp_wd = item_reg.random_byte & kk;
                    end
                    c8ex_pkg::OP_DRW, c8ex_pkg::OP_BCD,
                    c8ex_pkg::OP_STORE, c8ex_pkg::OP_LOAD: exec_to = c8ex_pkg::ST_MOD;
                    c8ex_pkg::OP_SKP, c8ex_pkg::OP_SKNP: begin
                        if (va > 8'd15) begin
                            err = c8ex_pkg::ERR_KEY;
                        end else begin
                            skip = item_reg.key_mask[va[3:0]] ^
                                   (c8ex_pkg::op_t'(item_reg.opcode) == c8ex_pkg::OP_SKNP);
                        end
                    end
                    c8ex_pkg::OP_LD_VDT: begin gp_we = 1'b1; gp_wd = delay_reg; end
                    c8ex_pkg::OP_LD_KEY: begin
                        if (item_reg.key_mask == 16'd0) begin
                            wt = 1'b1; new_pc = pc_reg;
                        end else begin
                            gp_we = 1'b1; gp_wd = {4'd0, key_lo};
                        end
                    end
                    c8ex_pkg::OP_LD_DT: delay_next = va;
                    c8ex_pkg::OP_LD_ST: sound_next = va;
                    c8ex_pkg::OP_ADD_I: begin
                        i_next = sum_i[11:0];
                        gp_we  = 1'b1; gp_wa = c8ex_pkg::FLAG_REG;
                        gp_wd  = {7'd0, (sum_i >= MEM_LIM)};
                    end
                    c8ex_pkg::OP_LD_F: begin
                        i_next = font_reg + {6'd0, va[3:0], 2'b00} + {8'd0, va[3:0]};
                    end
                    c8ex_pkg::OP_HOST_WR: begin
                        new_pc = pc_reg;
                        if ({1'b0, item_reg.immediate} >= MEM_LIM) begin
                            err = c8ex_pkg::ERR_ADDR;
                        end else begin
                            ram_we = 1'b1;
                            ram_wa = item_reg.immediate[AW-1:0];
                            ram_wd = item_reg.host_data;
                        end
                    end
                    c8ex_pkg::OP_ROW_RD: begin
                        new_pc = pc_reg;
                        if (item_reg.immediate >= 12'(SCR_HEIGHT)) begin
                            err = c8ex_pkg::ERR_ADDR;
                        end else begin
                            row_out = cur_row;
                        end
                    end
                    default: new_pc = pc_reg;
                endcase
                if (err != c8ex_pkg::ERR_OK) begin
                    new_pc = pc_reg;
                end else if (skip) begin
                    new_pc = new_pc + 12'd2;
                end
                pc_next  = new_pc;
                res_next = '{pc_value: new_pc, jumped: jmp, waiting: wt,
                             error_code: err, screen_row: row_out};
                state_next = exec_to;
            end
            c8ex_pkg::ST_FLAG: begin
                gp_we = 1'b1; gp_wa = c8ex_pkg::FLAG_REG; gp_wd = {7'd0, flag_reg};
                state_next = c8ex_pkg::ST_FIN;
            end
            c8ex_pkg::ST_MOD: begin
                if ({1'b0, addr_reg} >= MEM_LIM) begin
                    addr_next = addr_reg - MEM_LIM[11:0];
                end
                if (x0_reg >= SW_LIM) begin
                    x0_next = x0_reg - SW_LIM;
                end
                if (yw_reg >= SH_LIM) begin
                    yw_next = yw_reg - SH_LIM;
                end
                if (({1'b0, addr_reg} < MEM_LIM) && (x0_reg < SW_LIM) && (yw_reg < SH_LIM))
                begin
                    ptr_next = addr_reg[AW-1:0];
                    priority case (c8ex_pkg::op_t'(item_reg.opcode))
                        c8ex_pkg::OP_DRW:   state_next = c8ex_pkg::ST_DRR;
                        c8ex_pkg::OP_BCD:   state_next = c8ex_pkg::ST_BCD;
                        c8ex_pkg::OP_STORE: state_next = c8ex_pkg::ST_STR;
                        default:            state_next = c8ex_pkg::ST_LDR;
                    endcase
                end
            end
            c8ex_pkg::ST_BCD: begin
                ram_we = 1'b1; ram_wd = bcd_dig;
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd2) begin
                    state_next = c8ex_pkg::ST_FIN;
                end
            end
            c8ex_pkg::ST_STR: begin
                gp_ra = cnt_reg;
                state_next = c8ex_pkg::ST_STW;
            end
            c8ex_pkg::ST_STW: begin
                ram_we = 1'b1; ram_wd = va;
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 4'd1;
                state_next = (cnt_reg == item_reg.reg_x) ? c8ex_pkg::ST_FIN : c8ex_pkg::ST_STR;
            end
            c8ex_pkg::ST_LDR: state_next = c8ex_pkg::ST_LDW;
            c8ex_pkg::ST_LDW: begin
                gp_we = 1'b1; gp_wa = cnt_reg; gp_wd = ram_rd_reg;
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 4'd1;
                state_next = (cnt_reg == item_reg.reg_x) ? c8ex_pkg::ST_FIN : c8ex_pkg::ST_LDR;
            end
            c8ex_pkg::ST_DRR: begin
                state_next = ((cnt_reg < item_reg.immediate[3:0]) && (yw_reg < SH_LIM))
                             ? c8ex_pkg::ST_DRW : c8ex_pkg::ST_DRF;
            end
            c8ex_pkg::ST_DRW: begin
                scr_we   = 1'b1;
                scr_wd   = cur_row ^ spr_mask;
                hit_next = hit_reg | (|(cur_row & spr_mask));
                scr_vld_next[yw_reg[HW-1:0]] = 1'b1;
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 4'd1;
                yw_next  = yw_reg + 8'd1;
                state_next = c8ex_pkg::ST_DRR;
            end
            c8ex_pkg::ST_DRF: begin
                gp_we = 1'b1; gp_wa = c8ex_pkg::FLAG_REG; gp_wd = {7'd0, hit_reg};
                state_next = c8ex_pkg::ST_FIN;
            end
            c8ex_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = c8ex_pkg::ST_IDLE;
                end
            end
            default: state_next = c8ex_pkg::ST_IDLE;
        endcase

        if (gp_we) begin
            gp_vld_next[gp_wa] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= c8ex_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            pc_reg      <= c8ex_pkg::PC_RESET;
            i_reg       <= 12'd0;
            font_reg    <= c8ex_pkg::FONT_RESET;
            sp_reg      <= '0;
            delay_reg   <= 8'd0;
            sound_reg   <= 8'd0;
            gp_vld_reg  <= '0;
            scr_vld_reg <= '0;
            ptr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pc_reg      <= pc_next;
            i_reg       <= i_next;
            font_reg    <= font_next;
            sp_reg      <= sp_next;
            delay_reg   <= delay_next;
            sound_reg   <= sound_next;
            gp_vld_reg  <= gp_vld_next;
            scr_vld_reg <= scr_vld_next;
            ptr_reg     <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
        vx_reg     <= vx_next;
        flag_reg   <= flag_next;
        hit_reg    <= hit_next;
        addr_reg   <= addr_next;
        x0_reg     <= x0_next;
        yw_reg     <= yw_next;
        cnt_reg    <= cnt_next;
        gp_rda_v_reg <= gp_vld_reg[gp_ra];
        gp_rdb_v_reg <= gp_vld_reg[gp_rb];
        scr_rd_v_reg <= scr_vld_reg[scr_ra];
    end

    always_ff @(posedge aclk) begin
        if (gp_we) begin
            gp_mem[gp_wa] <= gp_wd;
        end
        gp_rda_reg <= gp_mem[gp_ra];
        gp_rdb_reg <= gp_mem[gp_rb];
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_wa] <= ram_wd;
        end
        ram_rd_reg <= ram_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_rd_reg <= stk_mem[stk_ra];
    end

    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scr_mem[scr_wa] <= scr_wd;
        end
        scr_rd_reg <= scr_mem[scr_ra];
    end

    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond depth");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != c8ex_pkg::ST_EXEC && state_reg != c8ex_pkg::ST_MOD) |->
        ptr_reg <= PTR_LAST)
        else $error("RAM walk pointer out of range");

    a_draw_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == c8ex_pkg::ST_DRW |-> (x0_reg < SW_LIM && yw_reg < SH_LIM))
        else $error("draw origin not reduced");

    a_err_no_jump: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item_reg.error_code != c8ex_pkg::ERR_OK) |-> !m_item_reg.jumped)
        else $error("jump reported with error");

endmodule
